// File: src/brsort_pkg.sv
// brsort_pkg: sizes, record and request/result types, and control structs
// shared by the binary radix record sorter modules. No dependencies.
`default_nettype none
package brsort_pkg;

	localparam int DEPTH       = 64;
	localparam int KEY_BITS    = 64;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int BIT_W       = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	// live ranges on the stack are disjoint and hold two or more records
	localparam int STACK_DEPTH = DEPTH / 2;
	localparam int STK_IW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] coord_a;
		logic [31:0] coord_b;
		logic [31:0] coord_c;
		logic [63:0] value_real;
		logic [63:0] value_imag;
		logic        last_in;
	} in_t;

	typedef struct packed {
		logic [63:0] out_key;
		logic [31:0] out_coord_a;
		logic [31:0] out_coord_b;
		logic [31:0] out_coord_c;
		logic [63:0] out_value_real;
		logic [63:0] out_value_imag;
		logic        last_out;
	} out_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] coord_a;
		logic [31:0] coord_b;
		logic [31:0] coord_c;
		logic [63:0] value_real;
		logic [63:0] value_imag;
	} rec_t;

	typedef enum logic [1:0] {
		WSRC_ITEM = 2'd0,
		WSRC_A    = 2'd1,
		WSRC_B    = 2'd2
	} wsrc_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
		logic             we;
		logic [IDX_W-1:0] waddr;
		wsrc_t            wsrc;
	} mem_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		logic [BIT_W-1:0] bitpos;
	} span_t;

endpackage
`default_nettype wire

// File: src/brsort_store.sv
// brsort_store: record memory, one write port and two registered read ports.
// Depends on brsort_pkg.
`default_nettype none
module brsort_store (
	input  wire logic                clk,
	input  wire brsort_pkg::mem_ctl_t mem_ctl,
	input  wire brsort_pkg::in_t     wr_item,
	output brsort_pkg::rec_t         rd_a,
	output brsort_pkg::rec_t         rd_b
);

	brsort_pkg::rec_t mem [brsort_pkg::DEPTH];
	brsort_pkg::rec_t rd_a_q;
	brsort_pkg::rec_t rd_b_q;
	brsort_pkg::rec_t wdata;

	always_comb begin
		case (mem_ctl.wsrc)
			brsort_pkg::WSRC_A: wdata = rd_a_q;
			brsort_pkg::WSRC_B: wdata = rd_b_q;
			default: begin
				wdata.key        = wr_item.key;
				wdata.coord_a    = wr_item.coord_a;
				wdata.coord_b    = wr_item.coord_b;
				wdata.coord_c    = wr_item.coord_c;
				wdata.value_real = wr_item.value_real;
				wdata.value_imag = wr_item.value_imag;
			end
		endcase
	end

	// read-before-write: an exchange writes one side while the other read
	// register still holds the old record
	always_ff @(posedge clk) begin
		if (mem_ctl.we) begin
			mem[mem_ctl.waddr] <= wdata;
		end
		if (mem_ctl.re) begin
			rd_a_q <= mem[mem_ctl.raddr_a];
			rd_b_q <= mem[mem_ctl.raddr_b];
		end
	end

	assign rd_a = rd_a_q;
	assign rd_b = rd_b_q;

endmodule
`default_nettype wire

// File: src/brsort_ctrl.sv
// brsort_ctrl: load counter, partition sequencer with shared bit-test and
// pointer compare, range stack memory and output sequencing. Uses brsort_pkg.
`default_nettype none
module brsort_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 last_in,
	input  wire logic [63:0]          key_a,
	input  wire logic [63:0]          key_b,
	output brsort_pkg::mem_ctl_t      mem_ctl,
	output logic                      busy,
	output logic                      result_valid,
	output logic                      last_out
);

	localparam int CNT_W = brsort_pkg::CNT_W;
	localparam int IDX_W = brsort_pkg::IDX_W;
	localparam int BIT_W = brsort_pkg::BIT_W;
	localparam int SP_W  = brsort_pkg::SP_W;
	localparam int STK_IW = brsort_pkg::STK_IW;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_READ  = 8'b0000_0010,
		ST_EVAL  = 8'b0000_0100,
		ST_SWAP1 = 8'b0000_1000,
		ST_SWAP2 = 8'b0001_0000,
		ST_NEXT  = 8'b0010_0000,
		ST_LOAD  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] lo_q, lo_d;
	logic [CNT_W-1:0] hi_q, hi_d;
	logic [CNT_W-1:0] l_q, l_d;
	logic [CNT_W-1:0] r_q, r_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [SP_W-1:0]  sp_q, sp_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic             emit_s1, emit_d;
	logic             last_s1, last_d;

	brsort_pkg::span_t stack_mem [brsort_pkg::STACK_DEPTH];
	brsort_pkg::span_t stack_rd_q;
	brsort_pkg::span_t push_span;
	logic              push_en;
	logic              pop_en;
	logic [SP_W-1:0]   sp_dec;

	logic             room;
	logic [CNT_W-1:0] count_nx;
	logic             lt;
	logic             ka;
	logic             kb;
	logic [CNT_W-1:0] lf;

	assign room     = count_q < CNT_W'(brsort_pkg::DEPTH);
	assign count_nx = count_q + CNT_W'(room);
	assign lt       = l_q < r_q;
	assign ka       = key_a[bit_q];
	assign kb       = key_b[bit_q];
	// a zero bit at the meeting point belongs to the lower half
	assign lf       = l_q + CNT_W'(!ka);
	assign sp_dec   = sp_q - SP_W'(1);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		n_d       = n_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		l_d       = l_q;
		r_d       = r_q;
		bit_d     = bit_q;
		sp_d      = sp_q;
		k_d       = k_q;
		emit_d    = 1'b0;
		last_d    = last_s1;
		push_en   = 1'b0;
		push_span = '{lf, hi_q, bit_q - BIT_W'(1)};
		pop_en    = 1'b0;
		mem_ctl         = '0;
		mem_ctl.raddr_a = l_q[IDX_W-1:0];
		mem_ctl.raddr_b = r_q[IDX_W-1:0];
		mem_ctl.waddr   = count_q[IDX_W-1:0];
		mem_ctl.wsrc    = brsort_pkg::WSRC_ITEM;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					mem_ctl.we = room;
					count_d    = count_nx;
					if (last_in) begin
						n_d     = count_nx;
						count_d = '0;
						sp_d    = '0;
						if (count_nx >= CNT_W'(2)) begin
							lo_d    = '0;
							hi_d    = count_nx;
							bit_d   = BIT_W'(brsort_pkg::KEY_BITS - 1);
							l_d     = '0;
							r_d     = count_nx - CNT_W'(1);
							state_d = ST_READ;
						end else begin
							k_d     = '0;
							state_d = ST_EMIT;
						end
					end
				end
			end
			ST_READ: begin
				mem_ctl.re = 1'b1;
				state_d    = ST_EVAL;
			end
			ST_EVAL: begin
				if (lt) begin
					if (!ka) begin
						l_d     = l_q + CNT_W'(1);
						state_d = ST_READ;
					end else if (kb) begin
						r_d     = r_q - CNT_W'(1);
						state_d = ST_READ;
					end else begin
						state_d = ST_SWAP1;
					end
				end else if (bit_q != '0) begin
					// upper half waits on the stack, lower half goes on at once, each only if it holds two or more records
					push_en = (hi_q - lf) >= CNT_W'(2);
					if (push_en) begin
						sp_d = sp_q + SP_W'(1);
					end
					if ((lf - lo_q) >= CNT_W'(2)) begin
						hi_d    = lf;
						bit_d   = bit_q - BIT_W'(1);
						l_d     = lo_q;
						r_d     = lf - CNT_W'(1);
						state_d = ST_READ;
					end else begin
						state_d = ST_NEXT;
					end
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_SWAP1: begin
				mem_ctl.we    = 1'b1;
				mem_ctl.waddr = l_q[IDX_W-1:0];
				mem_ctl.wsrc  = brsort_pkg::WSRC_B;
				state_d       = ST_SWAP2;
			end
			ST_SWAP2: begin
				mem_ctl.we    = 1'b1;
				mem_ctl.waddr = r_q[IDX_W-1:0];
				mem_ctl.wsrc  = brsort_pkg::WSRC_A;
				state_d       = ST_READ;
			end
			ST_NEXT: begin
				if (sp_q == '0) begin
					k_d     = '0;
					state_d = ST_EMIT;
				end else begin
					pop_en  = 1'b1;
					sp_d    = sp_dec;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				lo_d    = stack_rd_q.lo;
				hi_d    = stack_rd_q.hi;
				bit_d   = stack_rd_q.bitpos;
				l_d     = stack_rd_q.lo;
				r_d     = stack_rd_q.hi - CNT_W'(1);
				state_d = ST_READ;
			end
			ST_EMIT: begin
				if (k_q < n_q) begin
					mem_ctl.re      = 1'b1;
					mem_ctl.raddr_a = k_q[IDX_W-1:0];
					emit_d          = 1'b1;
					last_d          = (k_q + CNT_W'(1)) == n_q;
					k_d             = k_q + CNT_W'(1);
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			sp_q    <= '0;
			k_q     <= '0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			n_q     <= n_d;
			sp_q    <= sp_d;
			k_q     <= k_d;
			emit_s1 <= emit_d;
			last_s1 <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		l_q   <= l_d;
		r_q   <= r_d;
		bit_q <= bit_d;
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[sp_q[STK_IW-1:0]] <= push_span;
		end
		if (pop_en) begin
			stack_rd_q <= stack_mem[sp_dec[STK_IW-1:0]];
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = emit_s1;
	assign last_out     = last_s1;

endmodule
`default_nettype wire

// File: src/binary_radix_record_sort.sv
// Top level of the binary radix record sorter: ties the sequencer to the
// record memory. Depends on brsort_pkg, brsort_ctrl, brsort_store.
`default_nettype none
// Records are loaded one per request (start high while busy is low); up to
// 64 are kept and later ones are dropped. The request with last_in set
// raises busy, sorts the held records ascending by key with an in-place
// binary partition per key bit, from bit 63 down, and then puts them on
// result one per cycle, each marked by result_valid for a single cycle,
// with last_out on the final one. The receiver cannot hold results off.
// The sort runs on one record memory with two read ports and one write
// port: each pointer step is a read and a test, each exchange adds a test
// that moves no pointer and then two writes, each range ends with one more
// read and test, and each range taken from the range stack adds a pop and
// a load. A record is tested at a key bit only while its range holds two
// or more records. Once the output run is done, busy falls.
module binary_radix_record_sort (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire brsort_pkg::in_t item,
	output brsort_pkg::out_t     result,
	output logic                 result_valid
);

	brsort_pkg::mem_ctl_t mem_ctl;
	brsort_pkg::rec_t     rd_a;
	brsort_pkg::rec_t     rd_b;
	logic                 last_out;

	brsort_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_in      (item.last_in),
		.key_a        (rd_a.key),
		.key_b        (rd_b.key),
		.mem_ctl      (mem_ctl),
		.busy         (busy),
		.result_valid (result_valid),
		.last_out     (last_out)
	);

	brsort_store u_store (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.wr_item (item),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);

	assign result.out_key        = rd_a.key;
	assign result.out_coord_a    = rd_a.coord_a;
	assign result.out_coord_b    = rd_a.coord_b;
	assign result.out_coord_c    = rd_a.coord_c;
	assign result.out_value_real = rd_a.value_real;
	assign result.out_value_imag = rd_a.value_imag;
	assign result.last_out       = last_out;

`ifndef SYNTH
	// results only come out during the output run
	a_result_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// the run ends with the record marked last
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_out) |=> !result_valid)
		else $error("result after final record");

	// a record without last_in is stored while there is room, and the block stays ready
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last_in) |=> (!busy && !result_valid))
		else $error("busy after plain load request");
`endif

endmodule
`default_nettype wire
